// File: src/qoi_stream_decoder_assert.svh
// ----------------------------------------------------------------------------
// qoi stream decoder assertion macros
// implication checks, same cycle and next cycle, reported through $error
// ----------------------------------------------------------------------------
`ifndef QOI_STREAM_DECODER_ASSERT_SVH
`define QOI_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
`define QSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define QSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define QSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/qsd_pkg.sv
// ----------------------------------------------------------------------------
// qsd_pkg
// shared types, result codes and opcodes of the qoi stream decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qsd_pkg;

    localparam logic [31:0] MAGIC_WORD   = 32'h716F6966;
    localparam logic [28:0] MAX_PIX_RST  = 29'd400000000;
    localparam int          PROD_W       = 59;

    localparam logic [7:0]  OP_RGB       = 8'hFE;
    localparam logic [7:0]  OP_RGBA      = 8'hFF;
    localparam logic [1:0]  OPT_INDEX    = 2'b00;
    localparam logic [1:0]  OPT_DIFF     = 2'b01;
    localparam logic [1:0]  OPT_LUMA     = 2'b10;
    localparam logic [1:0]  OPT_RUN      = 2'b11;

    localparam logic [2:0]  ST_PIXEL     = 3'd0;
    localparam logic [2:0]  ST_HEADER    = 3'd1;
    localparam logic [2:0]  ST_DONE      = 3'd2;
    localparam logic [2:0]  ST_ERROR     = 3'd3;
    localparam logic [2:0]  ST_REJECT    = 3'd4;

    localparam logic [2:0]  PSEL_DIFF    = 3'd0;
    localparam logic [2:0]  PSEL_LUMA    = 3'd1;
    localparam logic [2:0]  PSEL_RGB     = 3'd2;
    localparam logic [2:0]  PSEL_RGBA    = 3'd3;
    localparam logic [2:0]  PSEL_IDX     = 3'd4;
    localparam logic [2:0]  PSEL_RUN     = 3'd5;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } pixel_t;

    typedef struct packed {
        logic       latch_byte;
        logic       shift_in;
        logic       clr_asm;
        logic       clr_cnt;
        logic       inc_cnt;
        logic       latch_width;
        logic       latch_height;
        logic       mul;
        logic       load_remaining;
        logic       latch_chan;
        logic       latch_op;
        logic       idx_read;
        logic       run_start;
        logic       run_dec;
        logic       load;
        logic [2:0] res_kind;
        logic [2:0] pix_sel;
        logic       last;
    } qsd_cmd_t;

    typedef struct packed {
        logic [2:0] cnt;
        logic [7:0] byte_val;
        logic       magic_ok;
        logic       hdr_fail;
        logic       rem_zero;
        logic       rem_one;
        logic       run_one;
        logic       out_free;
    } qsd_sts_t;

endpackage

`default_nettype wire

// File: src/qsd_byte_if.sv
// ----------------------------------------------------------------------------
// qsd_byte_if
// byte request channel into the decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// File: src/qsd_result_if.sv
// ----------------------------------------------------------------------------
// qsd_result_if
// result request channel out of the decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qsd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [2:0]  channel_count;
    logic [2:0]  color_space;
    logic        final_pixel;
    logic        last;

    modport source (output valid, output status, output red, output green, output blue,
                    output alpha, output image_width, output image_height,
                    output channel_count, output color_space, output final_pixel,
                    output last, input ready);
    modport sink   (input valid, input status, input red, input green, input blue,
                    input alpha, input image_width, input image_height,
                    input channel_count, input color_space, input final_pixel,
                    input last, output ready);
endinterface

`default_nettype wire

// File: src/qsd_ram.sv
// ----------------------------------------------------------------------------
// qsd_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire                      re,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/qsd_datapath.sv
// ----------------------------------------------------------------------------
// qsd_datapath
// field assembly, header check, pixel arithmetic, colour index and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qsd_datapath
    import qsd_pkg::*;
#(
    parameter int INDEX_ENTRIES = 64,
    parameter int COUNT_BITS    = 29
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire [28:0]       cfg_wdata,
    input  wire [7:0]        in_byte,
    input  wire qsd_cmd_t    cmd,
    output qsd_sts_t         sts,
    qsd_result_if.source     results
);

    localparam int IDX_BITS = $clog2(INDEX_ENTRIES);

    logic [28:0]           max_reg;
    logic [7:0]            byte_reg;
    logic [31:0]           asm_reg;
    logic [2:0]            cnt_reg;
    logic [7:0]            op_reg;
    logic [31:0]           width_reg;
    logic [31:0]           height_reg;
    logic [2:0]            chan_reg;
    pixel_t                prev_reg;
    logic [INDEX_ENTRIES-1:0] valid_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [6:0]            run_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  big_reg;
    logic [IDX_BITS-1:0]   idx_addr_reg;
    logic                  out_valid_reg;

    logic [31:0]           ram_rdata;
    pixel_t                pix;
    pixel_t                idx_pix;
    logic [7:0]            dg;
    logic [7:0]            hsum;
    logic [PROD_W-1:0]     total;
    logic [29:0]           h_inc;
    logic                  emit_pixel;

    assign emit_pixel = cmd.load && (cmd.res_kind == ST_PIXEL);
    assign idx_pix    = valid_reg[idx_addr_reg] ? pixel_t'(ram_rdata) : '0;
    assign dg         = {2'b00, op_reg[5:0]} - 8'd32;
    assign h_inc      = {1'b0, height_reg[28:0]} + 30'd1;
    assign total      = prod_reg - {{(PROD_W-32){1'b0}}, width_reg};

    always_comb
    begin
        pix = prev_reg;
        unique case (cmd.pix_sel)
            PSEL_DIFF:
            begin
                pix.r = prev_reg.r + {6'd0, byte_reg[5:4]} - 8'd2;
                pix.g = prev_reg.g + {6'd0, byte_reg[3:2]} - 8'd2;
                pix.b = prev_reg.b + {6'd0, byte_reg[1:0]} - 8'd2;
            end
            PSEL_LUMA:
            begin
                pix.r = prev_reg.r + dg + {4'd0, byte_reg[7:4]} - 8'd8;
                pix.g = prev_reg.g + dg;
                pix.b = prev_reg.b + dg + {4'd0, byte_reg[3:0]} - 8'd8;
            end
            PSEL_RGB:
            begin
                pix.r = asm_reg[23:16];
                pix.g = asm_reg[15:8];
                pix.b = asm_reg[7:0];
            end
            PSEL_RGBA:
            begin
                pix = {asm_reg[7:0], asm_reg[15:8], asm_reg[23:16], asm_reg[31:24]};
            end
            PSEL_IDX:
            begin
                pix = idx_pix;
            end
            default:
            begin
                pix = prev_reg;
            end
        endcase
    end

    assign hsum = 8'(pix.r * 8'd3 + pix.g * 8'd5 + pix.b * 8'd7 + pix.a * 8'd11);

    qsd_ram #(
        .WIDTH (32),
        .DEPTH (INDEX_ENTRIES)
    ) u_index (
        .clk   (clk),
        .we    (emit_pixel),
        .waddr (hsum[IDX_BITS-1:0]),
        .wdata (pix),
        .re    (cmd.idx_read),
        .raddr (byte_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_PIX_RST;
            byte_reg      <= '0;
            asm_reg       <= '0;
            cnt_reg       <= '0;
            op_reg        <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            chan_reg      <= '0;
            prev_reg      <= 32'hFF000000;
            valid_reg     <= '0;
            rem_reg       <= '0;
            run_reg       <= '0;
            prod_reg      <= '0;
            big_reg       <= 1'b0;
            idx_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_wdata;
            end
            if (cmd.latch_byte)
            begin
                byte_reg <= in_byte;
            end
            if (cmd.shift_in)
            begin
                asm_reg <= {asm_reg[23:0], in_byte};
                cnt_reg <= cnt_reg + 3'd1;
            end
            else if (cmd.clr_asm || emit_pixel)
            begin
                asm_reg <= '0;
                cnt_reg <= '0;
            end
            else if (cmd.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.inc_cnt)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (cmd.latch_width)
            begin
                width_reg <= asm_reg;
            end
            if (cmd.latch_height)
            begin
                height_reg <= asm_reg;
            end
            if (cmd.mul)
            begin
                big_reg  <= (|width_reg[31:29]) || (|height_reg[31:29]);
                prod_reg <= PROD_W'(h_inc * width_reg[28:0]);
            end
            if (cmd.latch_chan)
            begin
                chan_reg <= byte_reg[2:0];
            end
            if (cmd.latch_op)
            begin
                op_reg <= byte_reg;
            end
            if (cmd.idx_read)
            begin
                idx_addr_reg <= byte_reg[IDX_BITS-1:0];
            end
            if (cmd.run_start)
            begin
                run_reg <= {1'b0, byte_reg[5:0]} + 7'd1;
            end
            else if (cmd.run_dec)
            begin
                run_reg <= run_reg - 7'd1;
            end
            if (cmd.load_remaining)
            begin
                rem_reg <= total[COUNT_BITS-1:0];
            end
            else if (emit_pixel && (rem_reg != '0))
            begin
                rem_reg <= rem_reg - 1'b1;
            end
            if (emit_pixel)
            begin
                prev_reg                     <= pix;
                valid_reg[hsum[IDX_BITS-1:0]] <= 1'b1;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, zero outside the fields of its kind
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            results.status        <= cmd.res_kind;
            results.last          <= cmd.last;
            results.red           <= emit_pixel ? pix.r : 8'd0;
            results.green         <= emit_pixel ? pix.g : 8'd0;
            results.blue          <= emit_pixel ? pix.b : 8'd0;
            results.alpha         <= emit_pixel ? pix.a : 8'd0;
            results.final_pixel   <= emit_pixel && (rem_reg == COUNT_BITS'(1));
            if (cmd.res_kind == ST_HEADER)
            begin
                results.image_width   <= width_reg;
                results.image_height  <= height_reg;
                results.channel_count <= chan_reg;
                results.color_space   <= byte_reg[2:0];
            end
            else
            begin
                results.image_width   <= '0;
                results.image_height  <= '0;
                results.channel_count <= '0;
                results.color_space   <= '0;
            end
        end
    end

    assign results.valid = out_valid_reg;

    always_comb
    begin
        sts.cnt      = cnt_reg;
        sts.byte_val = byte_reg;
        sts.magic_ok = (asm_reg == MAGIC_WORD);
        sts.hdr_fail = (width_reg == '0) || big_reg
                       || (prod_reg > {{(PROD_W-29){1'b0}}, max_reg})
                       || (total[PROD_W-1:COUNT_BITS] != '0);
        sts.rem_zero = (rem_reg == '0);
        sts.rem_one  = (rem_reg == COUNT_BITS'(1));
        sts.run_one  = (run_reg == 7'd1);
        sts.out_free = !out_valid_reg || results.ready;
    end

endmodule

`default_nettype wire

// File: src/qsd_ctrl.sv
// ----------------------------------------------------------------------------
// qsd_ctrl
// parse phase and sequencing state machine of the qoi stream decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "qoi_stream_decoder_assert.svh"

module qsd_ctrl
    import qsd_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire           in_valid,
    output logic          in_ready,
    input  wire qsd_sts_t sts,
    output qsd_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_IDX  = 3'd4;
    localparam logic [2:0] S_RUN  = 3'd5;

    localparam logic [3:0] P_MAGIC  = 4'd0;
    localparam logic [3:0] P_WIDTH  = 4'd1;
    localparam logic [3:0] P_HEIGHT = 4'd2;
    localparam logic [3:0] P_CHAN   = 4'd3;
    localparam logic [3:0] P_CSPACE = 4'd4;
    localparam logic [3:0] P_OP     = 4'd5;
    localparam logic [3:0] P_RGB    = 4'd6;
    localparam logic [3:0] P_RGBA   = 4'd7;
    localparam logic [3:0] P_LUMA   = 4'd8;
    localparam logic [3:0] P_TAIL   = 4'd9;
    localparam logic [3:0] P_DEAD   = 4'd10;

    logic [2:0] state_reg, state_next;
    logic [3:0] phase_reg, phase_next;
    logic [7:0] d;

    assign d        = sts.byte_val;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_byte = 1'b1;
                    cmd.shift_in   = (phase_reg == P_MAGIC) || (phase_reg == P_WIDTH)
                                     || (phase_reg == P_HEIGHT) || (phase_reg == P_RGB)
                                     || (phase_reg == P_RGBA);
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (phase_reg)
                    P_MAGIC:
                    begin
                        if (sts.cnt == 3'd4)
                        begin
                            if (sts.magic_ok)
                            begin
                                cmd.clr_asm = 1'b1;
                                phase_next  = P_WIDTH;
                            end
                            else if (sts.out_free)
                            begin
                                cmd.load     = 1'b1;
                                cmd.res_kind = ST_ERROR;
                                cmd.last     = 1'b1;
                                phase_next   = P_DEAD;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                    end
                    P_WIDTH:
                    begin
                        if (sts.cnt == 3'd4)
                        begin
                            cmd.latch_width = 1'b1;
                            cmd.clr_asm     = 1'b1;
                            phase_next      = P_HEIGHT;
                        end
                    end
                    P_HEIGHT:
                    begin
                        if (sts.cnt == 3'd4)
                        begin
                            cmd.latch_height = 1'b1;
                            cmd.clr_asm      = 1'b1;
                            state_next       = S_MUL;
                        end
                    end
                    P_CHAN:
                    begin
                        if ((d == 8'd3) || (d == 8'd4))
                        begin
                            cmd.latch_chan = 1'b1;
                            phase_next     = P_CSPACE;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.load     = 1'b1;
                            cmd.res_kind = ST_ERROR;
                            cmd.last     = 1'b1;
                            phase_next   = P_DEAD;
                        end
                        else
                        begin
                            state_next = S_EXEC;
                        end
                    end
                    P_CSPACE:
                    begin
                        if (!sts.out_free)
                        begin
                            state_next = S_EXEC;
                        end
                        else if ((d == 8'd0) || (d == 8'd4))
                        begin
                            cmd.load     = 1'b1;
                            cmd.res_kind = ST_HEADER;
                            cmd.last     = 1'b1;
                            cmd.clr_cnt  = 1'b1;
                            phase_next   = sts.rem_zero ? P_TAIL : P_OP;
                        end
                        else
                        begin
                            cmd.load     = 1'b1;
                            cmd.res_kind = ST_ERROR;
                            cmd.last     = 1'b1;
                            phase_next   = P_DEAD;
                        end
                    end
                    P_OP:
                    begin
                        cmd.latch_op = 1'b1;
                        cmd.clr_asm  = 1'b1;
                        if (d == OP_RGB)
                        begin
                            phase_next = P_RGB;
                        end
                        else if (d == OP_RGBA)
                        begin
                            phase_next = P_RGBA;
                        end
                        else
                        begin
                            unique case (d[7:6])
                                OPT_INDEX:
                                begin
                                    cmd.idx_read = 1'b1;
                                    state_next   = S_IDX;
                                end
                                OPT_DIFF:
                                begin
                                    if (sts.out_free)
                                    begin
                                        cmd.load     = 1'b1;
                                        cmd.res_kind = ST_PIXEL;
                                        cmd.pix_sel  = PSEL_DIFF;
                                        cmd.last     = 1'b1;
                                        phase_next   = sts.rem_one ? P_TAIL : P_OP;
                                    end
                                    else
                                    begin
                                        state_next = S_EXEC;
                                    end
                                end
                                OPT_LUMA:
                                begin
                                    phase_next = P_LUMA;
                                end
                                OPT_RUN:
                                begin
                                    cmd.run_start = 1'b1;
                                    state_next    = S_RUN;
                                end
                                default:
                                begin
                                    state_next = S_IDLE;
                                end
                            endcase
                        end
                    end
                    P_RGB, P_RGBA, P_LUMA:
                    begin
                        if ((phase_reg == P_LUMA) || (sts.cnt == 3'd4)
                            || ((phase_reg == P_RGB) && (sts.cnt == 3'd3)))
                        begin
                            if (sts.out_free)
                            begin
                                cmd.load     = 1'b1;
                                cmd.res_kind = ST_PIXEL;
                                cmd.last     = 1'b1;
                                cmd.pix_sel  = (phase_reg == P_RGB) ? PSEL_RGB :
                                               (phase_reg == P_RGBA) ? PSEL_RGBA : PSEL_LUMA;
                                phase_next   = sts.rem_one ? P_TAIL : P_OP;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                    end
                    P_TAIL:
                    begin
                        if ((sts.cnt < 3'd7) && (d == 8'd0))
                        begin
                            cmd.inc_cnt = 1'b1;
                        end
                        else if (!sts.out_free)
                        begin
                            state_next = S_EXEC;
                        end
                        else
                        begin
                            cmd.load     = 1'b1;
                            cmd.last     = 1'b1;
                            cmd.res_kind = ((sts.cnt == 3'd7) && (d == 8'd1)) ? ST_DONE
                                                                              : ST_ERROR;
                            phase_next   = P_DEAD;
                        end
                    end
                    P_DEAD:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.load     = 1'b1;
                            cmd.res_kind = ST_REJECT;
                            cmd.last     = 1'b1;
                        end
                        else
                        begin
                            state_next = S_EXEC;
                        end
                    end
                    default:
                    begin
                        phase_next = P_DEAD;
                    end
                endcase
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!sts.hdr_fail)
                begin
                    cmd.load_remaining = 1'b1;
                    phase_next         = P_CHAN;
                    state_next         = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.res_kind = ST_ERROR;
                    cmd.last     = 1'b1;
                    phase_next   = P_DEAD;
                    state_next   = S_IDLE;
                end
            end
            S_IDX:
            begin
                if (sts.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.res_kind = ST_PIXEL;
                    cmd.pix_sel  = PSEL_IDX;
                    cmd.last     = 1'b1;
                    phase_next   = sts.rem_one ? P_TAIL : P_OP;
                    state_next   = S_IDLE;
                end
            end
            S_RUN:
            begin
                if (sts.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.res_kind = ST_PIXEL;
                    cmd.pix_sel  = PSEL_RUN;
                    cmd.run_dec  = 1'b1;
                    cmd.last     = sts.run_one || sts.rem_one;
                    phase_next   = sts.rem_one ? P_TAIL : P_OP;
                    if (sts.run_one || sts.rem_one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= P_MAGIC;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    `QSD_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load, sts.out_free, "result loaded over a held one")
    `QSD_ASSERT_NXT(a_accept_exec, clk, rst_n, (state_reg == S_IDLE) && in_valid, (state_reg == S_EXEC), "accepted byte not executed")
    `QSD_ASSERT_NXT(a_idx_wait, clk, rst_n, cmd.idx_read, (state_reg == S_IDX), "index read without wait")
    `QSD_ASSERT_NXT(a_run_end, clk, rst_n, (state_reg == S_RUN) && cmd.load && cmd.last, (state_reg == S_IDLE), "run did not end")

endmodule

`default_nettype wire

// File: src/qoi_stream_decoder.sv
// ----------------------------------------------------------------------------
// qoi_stream_decoder
// byte serial qoi image decoder, header check, pixel ops and tail check
// ----------------------------------------------------------------------------
// usage
// bytes carries the file one byte per request; results carries one result per
// request: a header, a pixel, done, a format error, or a reject after the end.
// last marks the final result caused by a byte; final_pixel the image's last
// pixel. cfg_we with cfg_wdata writes max_pixels; the user must write it
// only while the block is idle, the block itself does not enforce this.
// a byte is taken when the block is idle; an index op then waits for the
// index read, the last height byte for a registered multiply, then compare,
// and a run gives one pixel per cycle from the output register while it is free.
// a pending result does not block the next byte; the byte waits only when it
// produces a result and the output register is still held by the receiver.
// reset clears the parse state, the previous pixel to opaque black, the 64
// colour index valid bits and sets max_pixels to 400000000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qoi_stream_decoder
    import qsd_pkg::*;
#(
    parameter int INDEX_ENTRIES = 64,
    parameter int COUNT_BITS    = 29
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire [28:0]   cfg_wdata,
    qsd_byte_if.sink     bytes,
    qsd_result_if.source results
);

    qsd_cmd_t cmd;
    qsd_sts_t sts;

    qsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_ready (bytes.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    qsd_datapath #(
        .INDEX_ENTRIES (INDEX_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_byte   (bytes.data_byte),
        .cmd       (cmd),
        .sts       (sts),
        .results   (results)
    );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// qoi stream decoder testbench
// Feeds one QOI file through the byte channel: a directed header and one of
// each op, then random op groups until the image ends. After that come the
// tail and a stretch of bytes that must all be rejected. Every result is
// compared, field by field, against an in-bench decoder. Both handshakes idle
// at random, and the pixel limit is rewritten at idle points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import qsd_pkg::*;

    localparam int            CYCLE_LIMIT = 400000;
    localparam int            DRAIN_WAIT  = 100;
    localparam logic [28:0]   PIX_MAX     = 29'h1FFFFFFF;
    localparam longint unsigned COUNT_MASK = (64'd1 << 29) - 1;
    localparam logic [31:0]   IMG_W       = 32'd64;
    localparam logic [31:0]   IMG_H       = 32'd12;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_CHAN, PH_CSPACE, PH_OP,
        PH_RGB, PH_RGBA, PH_LUMA, PH_TAIL, PH_DEAD
    } parse_phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [2:0]  channel_count;
        logic [2:0]  color_space;
        logic        final_pixel;
        logic        last;
    } decode_result_t;

    typedef struct {
        logic [7:0] data;
        bit         typed;
        logic [2:0] status;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [28:0] cfg_wdata;

    qsd_byte_if   bytes_ch ();
    qsd_result_if results_ch ();

    qoi_stream_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bytes     (bytes_ch),
        .results   (results_ch)
    );

    decode_result_t  pending_results[$];
    int              mismatches;
    int              cycle_count;
    int              burst_left;

    parse_phase_t    phase;
    logic [2:0]      field_cnt;
    logic [31:0]     asm_buf;
    logic [7:0]      op_byte;
    logic [31:0]     width_q;
    logic [31:0]     height_q;
    pixel_t          prev_px;
    pixel_t          colour_index[64];
    logic [28:0]     remaining;
    logic [28:0]     pixel_limit;
    int              new_results;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic void push_result(decode_result_t res);
        pending_results.push_back(res);
        new_results++;
    endfunction

    function automatic void push_status(logic [2:0] st);
        decode_result_t res;
        res        = '0;
        res.status = st;
        push_result(res);
    endfunction

    function automatic void fail_image();
        push_status(ST_ERROR);
        phase = PH_DEAD;
    endfunction

    function automatic void emit_pixel(pixel_t px);
        decode_result_t res;
        int unsigned    slot;
        res        = '0;
        res.status = ST_PIXEL;
        res.red    = px.r;
        res.green  = px.g;
        res.blue   = px.b;
        res.alpha  = px.a;
        prev_px    = px;
        slot       = (px.r * 3 + px.g * 5 + px.b * 7 + px.a * 11) & 63;
        colour_index[slot] = px;
        if (remaining > 0)
            remaining = remaining - 1;
        if (remaining == 0)
        begin
            res.final_pixel = 1'b1;
            phase           = PH_TAIL;
        end
        else
            phase = PH_OP;
        asm_buf   = '0;
        field_cnt = '0;
        push_result(res);
    endfunction

    function automatic void decode_byte(logic [7:0] d);
        pixel_t           p;
        pixel_t           px;
        bit               full;
        logic [7:0]       dg;
        longint unsigned  total;
        int               run_len;
        decode_result_t   res;
        p           = prev_px;
        new_results = 0;
        if (phase inside {PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_RGB, PH_RGBA})
        begin
            asm_buf   = {asm_buf[23:0], d};
            field_cnt = field_cnt + 3'd1;
        end
        full = field_cnt >= ((phase == PH_RGB) ? 3 : 4);
        case (phase)
            PH_MAGIC:
                if (full)
                begin
                    if (asm_buf != MAGIC_WORD)
                        fail_image();
                    else
                    begin
                        asm_buf   = '0;
                        field_cnt = '0;
                        phase     = PH_WIDTH;
                    end
                end
            PH_WIDTH:
                if (full)
                begin
                    width_q   = asm_buf;
                    asm_buf   = '0;
                    field_cnt = '0;
                    phase     = PH_HEIGHT;
                end
            PH_HEIGHT:
                if (full)
                begin
                    height_q  = asm_buf;
                    asm_buf   = '0;
                    field_cnt = '0;
                    total     = longint'(width_q) * longint'(height_q);
                    if (width_q == 0 || total > COUNT_MASK ||
                        (longint'(height_q) + 1) * longint'(width_q) > longint'(pixel_limit))
                        fail_image();
                    else
                    begin
                        remaining = total[28:0];
                        phase     = PH_CHAN;
                    end
                end
            PH_CHAN:
                if (d != 8'd3 && d != 8'd4)
                    fail_image();
                else
                begin
                    op_byte = d;
                    phase   = PH_CSPACE;
                end
            PH_CSPACE:
                if (d != 8'd0 && d != 8'd4)
                    fail_image();
                else
                begin
                    res               = '0;
                    res.status        = ST_HEADER;
                    res.image_width   = width_q;
                    res.image_height  = height_q;
                    res.channel_count = op_byte[2:0];
                    res.color_space   = d[2:0];
                    push_result(res);
                    op_byte   = '0;
                    phase     = (remaining == 0) ? PH_TAIL : PH_OP;
                    field_cnt = '0;
                end
            PH_OP:
            begin
                op_byte   = d;
                asm_buf   = '0;
                field_cnt = '0;
                if (d == OP_RGB)
                    phase = PH_RGB;
                else if (d == OP_RGBA)
                    phase = PH_RGBA;
                else
                    case (d[7:6])
                        OPT_INDEX: emit_pixel(colour_index[d[5:0]]);
                        OPT_DIFF:
                        begin
                            px   = p;
                            px.r = p.r + {6'd0, d[5:4]} - 8'd2;
                            px.g = p.g + {6'd0, d[3:2]} - 8'd2;
                            px.b = p.b + {6'd0, d[1:0]} - 8'd2;
                            emit_pixel(px);
                        end
                        OPT_LUMA: phase = PH_LUMA;
                        default:
                        begin
                            run_len = d[5:0] + 1;
                            for (int i = 0; i < run_len && remaining > 0; i++)
                                emit_pixel(prev_px);
                        end
                    endcase
            end
            PH_RGB:
                if (full)
                begin
                    px.r = asm_buf[23:16];
                    px.g = asm_buf[15:8];
                    px.b = asm_buf[7:0];
                    px.a = p.a;
                    emit_pixel(px);
                end
            PH_RGBA:
                if (full)
                begin
                    px.r = asm_buf[31:24];
                    px.g = asm_buf[23:16];
                    px.b = asm_buf[15:8];
                    px.a = asm_buf[7:0];
                    emit_pixel(px);
                end
            PH_LUMA:
            begin
                dg   = {2'd0, op_byte[5:0]} - 8'd32;
                px.r = p.r + dg + {4'd0, d[7:4]} - 8'd8;
                px.g = p.g + dg;
                px.b = p.b + dg + {4'd0, d[3:0]} - 8'd8;
                px.a = p.a;
                emit_pixel(px);
            end
            PH_TAIL:
                if (field_cnt < 3'd7)
                begin
                    if (d == 8'd0)
                        field_cnt = field_cnt + 3'd1;
                    else
                        fail_image();
                end
                else if (d == 8'd1)
                begin
                    push_status(ST_DONE);
                    phase = PH_DEAD;
                end
                else
                    fail_image();
            default:
            begin
                push_status(ST_REJECT);
                phase = PH_DEAD;
            end
        endcase
        if (new_results > 0)
            pending_results[$].last = 1'b1;
    endfunction

    task automatic send_byte(logic [7:0] b);
        @(negedge clk);
        if (burst_left == 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        forever
        begin
            @(posedge clk);
            if (bytes_ch.ready)
                break;
        end
        decode_byte(b);
        burst_left--;
    endtask

    task automatic drain_results();
        @(negedge clk);
        bytes_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_limit(logic [28:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        pixel_limit = value;
    endtask

    task automatic send_random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (remaining < 16)
            send_byte(8'hFD);
        else if (pick < 10)
        begin
            send_byte(OP_RGB);
            repeat (3) send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 18)
        begin
            send_byte(OP_RGBA);
            repeat (4) send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 40)
            send_byte({OPT_INDEX, 6'($urandom_range(0, 63))});
        else if (pick < 65)
            send_byte({OPT_DIFF, 6'($urandom_range(0, 63))});
        else if (pick < 85)
        begin
            send_byte({OPT_LUMA, 6'($urandom_range(0, 63))});
            send_byte(8'($urandom_range(0, 255)));
        end
        else
            send_byte({OPT_RUN, 6'($urandom_range(0, 61))});
    endtask

    always @(posedge clk)
    begin
        decode_result_t want;
        decode_result_t got;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            got.status        = results_ch.status;
            got.red           = results_ch.red;
            got.green         = results_ch.green;
            got.blue          = results_ch.blue;
            got.alpha         = results_ch.alpha;
            got.image_width   = results_ch.image_width;
            got.image_height  = results_ch.image_height;
            got.channel_count = results_ch.channel_count;
            got.color_space   = results_ch.color_space;
            got.final_pixel   = results_ch.final_pixel;
            got.last          = results_ch.last;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        int mode;
        int hold;
        if (hold > 0)
        begin
            hold--;
            results_ch.ready <= 1'b0;
        end
        else if (cycle_count == 600)
        begin
            hold = 400;
            results_ch.ready <= 1'b0;
        end
        else
        begin
            if (cycle_count % 64 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       results_ch.ready <= 1'b1;
                1:       results_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       results_ch.ready <= ($urandom_range(0, 3) == 0);
                default: results_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed[$];
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        bytes_ch.valid     = 1'b0;
        bytes_ch.data_byte = '0;
        results_ch.ready   = 1'b0;
        mismatches         = 0;
        cycle_count        = 0;
        burst_left         = 0;
        phase              = PH_MAGIC;
        field_cnt          = '0;
        asm_buf            = '0;
        op_byte            = '0;
        width_q            = '0;
        height_q           = '0;
        prev_px            = 32'hFF000000;
        remaining          = '0;
        pixel_limit        = MAX_PIX_RST;
        foreach (colour_index[i])
            colour_index[i] = '0;

        directed = '{
            '{8'h71, 0, ST_PIXEL}, '{8'h6F, 0, ST_PIXEL},
            '{8'h69, 0, ST_PIXEL}, '{8'h66, 0, ST_PIXEL},
            '{IMG_W[31:24], 0, ST_PIXEL}, '{IMG_W[23:16], 0, ST_PIXEL},
            '{IMG_W[15:8], 0, ST_PIXEL}, '{IMG_W[7:0], 0, ST_PIXEL},
            '{IMG_H[31:24], 0, ST_PIXEL}, '{IMG_H[23:16], 0, ST_PIXEL},
            '{IMG_H[15:8], 0, ST_PIXEL}, '{IMG_H[7:0], 0, ST_PIXEL},
            '{8'd4, 0, ST_PIXEL}, '{8'd4, 1, ST_HEADER},
            '{OP_RGB, 0, ST_PIXEL}, '{8'h00, 0, ST_PIXEL},
            '{8'hFF, 0, ST_PIXEL}, '{8'h80, 1, ST_PIXEL},
            '{OP_RGBA, 0, ST_PIXEL}, '{8'hFF, 0, ST_PIXEL},
            '{8'h00, 0, ST_PIXEL}, '{8'hFF, 0, ST_PIXEL},
            '{8'h00, 1, ST_PIXEL},
            '{8'h00, 1, ST_PIXEL}, '{8'h3F, 1, ST_PIXEL},
            '{8'h40, 0, ST_PIXEL}, '{8'h7F, 0, ST_PIXEL},
            '{8'h80, 0, ST_PIXEL}, '{8'h00, 0, ST_PIXEL},
            '{8'hBF, 0, ST_PIXEL}, '{8'hFF, 0, ST_PIXEL},
            '{8'hC0, 0, ST_PIXEL}, '{8'hFD, 0, ST_PIXEL}
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(negedge clk);
        write_limit(29'd1);
        write_limit(PIX_MAX);
        write_limit(29'((IMG_H + 1) * IMG_W));

        foreach (directed[i])
        begin
            send_byte(directed[i].data);
            if (directed[i].typed &&
                (new_results == 0 || pending_results[$].status !== directed[i].status))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("byte %0d: expected status %0d", i, directed[i].status);
            end
        end

        for (int k = 0; phase != PH_TAIL; k++)
        begin
            if (k == 40)
            begin
                drain_results();
                write_limit(29'($urandom_range(1, 32'h1FFFFFFF)));
            end
            if (k == 100)
            begin
                drain_results();
                write_limit(PIX_MAX);
            end
            send_random_op();
        end

        repeat (7) send_byte(8'h00);
        send_byte(8'h01);
        repeat (24) send_byte(8'($urandom_range(0, 255)));
        drain_results();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+src
src/qsd_pkg.sv
src/qsd_byte_if.sv
src/qsd_result_if.sv
src/qsd_ram.sv
src/qsd_datapath.sv
src/qsd_ctrl.sv
src/qoi_stream_decoder.sv
verif/testbench.sv
